[hdl/report_frame_receiver_assert.svh]
// Assertion macros for the report frame receiver.
`ifndef REPORT_FRAME_RECEIVER_ASSERT_SVH
`define REPORT_FRAME_RECEIVER_ASSERT_SVH
`ifndef SYNTHESIS
`define RFR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("report_frame_receiver assertion failed");
`define RFR_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("report_frame_receiver assertion failed");
`else
`define RFR_ASSERT_SAME(label, clk, rst, ante, cons)
`define RFR_ASSERT_ALWAYS(label, clk, ante, cons)
`endif
`endif

[hdl/rfr_pkg.sv]
// Shared types and constants of the report frame receiver.
package rfr_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEAD    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_OWN_ADDRESS   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_QUERY_COMMAND = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_GAP_TICKS     = 2'd3;

   localparam logic [7:0]  FRAME_HEAD_RESET    = 8'hF5;
   localparam logic [7:0]  OWN_ADDRESS_RESET   = 8'h00;
   localparam logic [7:0]  QUERY_COMMAND_RESET = 8'h01;
   localparam logic [15:0] GAP_TICKS_RESET     = 16'd200;

   // Kind of an input request.
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // Frame byte positions, counted from one.
   localparam int POS_HEAD    = 1;
   localparam int POS_ADDRESS = 2;
   localparam int POS_COMMAND = 3;
   localparam int POS_LENGTH  = 4;
   localparam int FRAME_OVERHEAD = 5;
   localparam int HEADER_BYTES   = 4;

   localparam int JOB_QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0]  frame_head;
      logic [7:0]  own_address;
      logic [7:0]  query_command;
      logic [15:0] gap_ticks;
   } cfg_type;

   typedef struct packed {
      logic       truncated;
      logic [7:0] power_level;
      logic [7:0] error_code;
      logic [7:0] device_type;
      logic [7:0] node_address;
   } job_head_type;

endpackage

[hdl/rfr_front.sv]
// Front end: deframes received bytes, tracks idle time and queues report jobs.
module rfr_front #(
   parameter int MAX_WORDS = 8,
   parameter int MAX_FRAME = 128,
   parameter int SHOWN_W   = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rfr_pkg::cfg_type          cfg,
   input  logic                      item_accept,
   input  logic                      item_type,
   input  logic [7:0]                item_byte,
   output logic                      job_push,
   output rfr_pkg::job_head_type     job_head,
   output logic [SHOWN_W-1:0]        job_shown,
   output logic [16*MAX_WORDS-1:0]   job_words
);

   localparam int STORE_DEPTH = rfr_pkg::HEADER_BYTES + 2 * MAX_WORDS;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int PW          = $clog2(MAX_FRAME + 1);
   localparam int CW          = 10;

   logic [PW-1:0]  bpos_ff, bpos_in;
   logic [7:0]     len_ff, len_in;
   logic [7:0]     cmd_ff, cmd_in;
   logic [7:0]     sum_ff, sum_in;
   logic [15:0]    idle_ff, idle_in;
   logic [7:0]     store_ff [STORE_DEPTH];

   logic [PW-1:0]  pos;
   logic [PW-1:0]  idx;
   logic           store_we;
   logic [6:0]     words;
   logic           frame_done;

   always_comb begin
      pos = ((idle_ff > cfg.gap_ticks) ? '0 : bpos_ff) + PW'(1);
      idx = pos - PW'(rfr_pkg::FRAME_OVERHEAD);
   end

   always_comb begin
      bpos_in    = bpos_ff;
      len_in     = len_ff;
      cmd_in     = cmd_ff;
      sum_in     = sum_ff;
      idle_in    = idle_ff;
      store_we   = 1'b0;
      frame_done = 1'b0;
      if (item_accept) begin
         if (item_type == rfr_pkg::REQ_TICK) begin
            if (idle_ff != 16'hFFFF) begin
               idle_in = idle_ff + 16'd1;
            end
         end else begin
            idle_in = '0;
            bpos_in = pos;
            if (pos == PW'(rfr_pkg::POS_HEAD)) begin
               if (item_byte != cfg.frame_head) begin
                  bpos_in = '0;
               end
            end else if (pos == PW'(rfr_pkg::POS_ADDRESS)) begin
               if (item_byte != cfg.own_address) begin
                  bpos_in = '0;
               end
            end else if (pos == PW'(rfr_pkg::POS_COMMAND)) begin
               cmd_in = item_byte;
            end else if (pos == PW'(rfr_pkg::POS_LENGTH)) begin
               len_in = item_byte;
               sum_in = '0;
               if (CW'(rfr_pkg::FRAME_OVERHEAD) + CW'(item_byte) > CW'(MAX_FRAME)) begin
                  bpos_in = '0;
               end
            end else if (CW'(pos) < CW'(rfr_pkg::FRAME_OVERHEAD) + CW'(len_ff)) begin
               sum_in   = sum_ff + item_byte;
               store_we = (CW'(idx) < CW'(STORE_DEPTH));
            end else begin
               frame_done = 1'b1;
               bpos_in    = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpos_ff <= '0;
         len_ff  <= '0;
         cmd_ff  <= '0;
         sum_ff  <= '0;
         idle_ff <= '0;
      end else begin
         bpos_ff <= bpos_in;
         len_ff  <= len_in;
         cmd_ff  <= cmd_in;
         sum_ff  <= sum_in;
         idle_ff <= idle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[idx[STORE_AW-1:0]] <= item_byte;
      end
   end

   // A good query frame with at least the four header bytes yields a job.
   always_comb begin
      words     = 7'((len_ff - 8'(rfr_pkg::HEADER_BYTES)) >> 1);
      job_push  = frame_done && (item_byte == sum_ff) && (cmd_ff == cfg.query_command)
                  && (len_ff >= 8'(rfr_pkg::HEADER_BYTES));
      job_head.node_address = store_ff[0];
      job_head.device_type  = store_ff[1];
      job_head.error_code   = store_ff[2];
      job_head.power_level  = store_ff[3];
      job_head.truncated    = ({1'b0, words} > 8'(MAX_WORDS));
      job_shown = job_head.truncated ? SHOWN_W'(MAX_WORDS) : SHOWN_W'(words);
   end

   for (genvar w = 0; w < MAX_WORDS; w++) begin : g_words
      assign job_words[16*w +: 16] = {store_ff[rfr_pkg::HEADER_BYTES + 2*w + 1],
                                      store_ff[rfr_pkg::HEADER_BYTES + 2*w]};
   end

endmodule

[hdl/rfr_job_fifo.sv]
// Short queue of report jobs between the front end and the result engine.
module rfr_job_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty,
   output logic             full
);

   localparam int DEPTH = rfr_pkg::JOB_QUEUE_DEPTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW  = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;

   always_comb begin
      empty     = (count_ff == '0);
      full      = (count_ff == CNTW'(DEPTH));
      head_data = mem_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/rfr_back.sv]
// Result engine: walks a report job and sends one result per shown word, or one empty result if it has none.
module rfr_back #(
   parameter int MAX_WORDS = 8,
   parameter int SHOWN_W   = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_ready,
   input  rfr_pkg::job_head_type   job_head,
   input  logic [SHOWN_W-1:0]      job_shown,
   input  logic [16*MAX_WORDS-1:0] job_words,
   output logic                    job_pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [55:0]             rsp_tdata,
   output logic [1:0]              rsp_tuser,
   output logic                    rsp_tlast
);

   localparam int KW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

   logic                    busy_ff, busy_in;
   logic [KW-1:0]           k_ff, k_in;
   rfr_pkg::job_head_type   head_ff;
   logic [SHOWN_W-1:0]      shown_ff;
   logic [16*MAX_WORDS-1:0] words_ff;

   logic                    valid_ff, valid_in;
   logic [55:0]             data_ff;
   logic [1:0]              user_ff;
   logic                    last_ff;

   logic                    slot_free;
   logic                    emit;
   logic                    has_words;
   logic                    is_last;
   logic [15:0]             word;

   always_comb begin
      slot_free = !valid_ff || rsp_tready;
      emit      = busy_ff && slot_free;
      job_pop   = !busy_ff && job_ready;
      has_words = (shown_ff != '0);
      is_last   = !has_words || (SHOWN_W'(k_ff) + SHOWN_W'(1) == shown_ff);
      word      = has_words ? words_ff[16*k_ff +: 16] : 16'd0;

      busy_in  = busy_ff;
      k_in     = k_ff;
      valid_in = valid_ff;
      if (job_pop) begin
         busy_in = 1'b1;
         k_in    = '0;
      end else if (emit) begin
         busy_in = !is_last;
         k_in    = k_ff + KW'(1);
      end
      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         k_ff     <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         k_ff     <= k_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         head_ff  <= job_head;
         shown_ff <= job_shown;
         words_ff <= job_words;
      end
      if (emit) begin
         data_ff <= {5'd0, word, 3'(k_ff), head_ff.power_level, head_ff.error_code,
                     head_ff.device_type, head_ff.node_address};
         user_ff <= {head_ff.truncated, has_words};
         last_ff <= is_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

[hdl/report_frame_receiver.sv]
// Top level of the report frame receiver: settings, front end, job queue, result engine.
//
// The request channel carries received bytes (req_tuser 0, byte in req_tdata) and
// idle time ticks (req_tuser 1). Frames are head, address, command, length,
// payload and an additive payload checksum. A good query frame with at least four
// payload bytes turns into one report: a run of results on the rsp channel, one per
// 16-bit data word up to MAX_WORDS (or one empty result), the final one marked by rsp_tlast.
// The front end takes one request per cycle while req_tready is high. The checksum
// byte of a good query frame puts a job into a two-entry queue; the result engine
// loads the job from the queue into its own registers once it is free, then
// registers one result per cycle in its output register while rsp_tready is high.
// The result engine loads the next job only once the last result of a report is
// in its output register.
// req_tready drops only while the job queue holds two waiting reports, which
// happens when the result receiver stalls for long.
// Settings are to be written through csr_we, csr_index and csr_wdata only while the
// block is idle; the block itself does not enforce this. Reset clears the deframer,
// the queue and the output register and restores the default settings; no result is valid right after reset.
`include "report_frame_receiver_assert.svh"

module report_frame_receiver #(
   parameter int MAX_WORDS = 8,
   parameter int MAX_FRAME = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] rx_byte
   input  logic                              req_tuser,   // [0] req_type
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] node_address, [15:8] device_type, [23:16] error_code,
   // [31:24] power_level, [34:32] word_index, [50:35] data_word, [55:51] zero
   output logic [55:0]                       rsp_tdata,
   output logic [1:0]                        rsp_tuser,   // [0] word_valid, [1] words_truncated
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [rfr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rfr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int SHOWN_W = $clog2(MAX_WORDS + 1);
   localparam int HEAD_W  = $bits(rfr_pkg::job_head_type);
   localparam int JOB_W   = HEAD_W + SHOWN_W + 16 * MAX_WORDS;

   rfr_pkg::cfg_type        cfg_ff;
   logic                    req_accept;
   logic                    job_push;
   rfr_pkg::job_head_type   push_head;
   logic [SHOWN_W-1:0]      push_shown;
   logic [16*MAX_WORDS-1:0] push_words;
   logic [JOB_W-1:0]        q_head;
   logic                    q_empty;
   logic                    q_full;
   logic                    job_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_head    <= rfr_pkg::FRAME_HEAD_RESET;
         cfg_ff.own_address   <= rfr_pkg::OWN_ADDRESS_RESET;
         cfg_ff.query_command <= rfr_pkg::QUERY_COMMAND_RESET;
         cfg_ff.gap_ticks     <= rfr_pkg::GAP_TICKS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            rfr_pkg::REG_FRAME_HEAD:    cfg_ff.frame_head    <= csr_wdata[7:0];
            rfr_pkg::REG_OWN_ADDRESS:   cfg_ff.own_address   <= csr_wdata[7:0];
            rfr_pkg::REG_QUERY_COMMAND: cfg_ff.query_command <= csr_wdata[7:0];
            rfr_pkg::REG_GAP_TICKS:     cfg_ff.gap_ticks     <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   assign req_tready = !q_full;
   assign req_accept = req_tvalid && req_tready;

   rfr_front #(
      .MAX_WORDS (MAX_WORDS),
      .MAX_FRAME (MAX_FRAME),
      .SHOWN_W   (SHOWN_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .item_accept (req_accept),
      .item_type   (req_tuser),
      .item_byte   (req_tdata),
      .job_push    (job_push),
      .job_head    (push_head),
      .job_shown   (push_shown),
      .job_words   (push_words)
   );

   rfr_job_fifo #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data ({push_head, push_shown, push_words}),
      .pop       (job_pop),
      .head_data (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   rfr_back #(
      .MAX_WORDS (MAX_WORDS),
      .SHOWN_W   (SHOWN_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_ready  (!q_empty),
      .job_head   (q_head[JOB_W-1 -: HEAD_W]),
      .job_shown  (q_head[16*MAX_WORDS +: SHOWN_W]),
      .job_words  (q_head[16*MAX_WORDS-1:0]),
      .job_pop    (job_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // A job is only produced by an accepted byte, so the queue can never overflow.
   `RFR_ASSERT_SAME(a_no_overflow, clock, reset, job_push, req_accept && !q_full)
   // An empty report is always a single, final result.
   `RFR_ASSERT_SAME(a_empty_is_last, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tlast)
   // The output register comes out of reset empty.
   `RFR_ASSERT_ALWAYS(a_reset_idle, clock, $fell(reset), !rsp_tvalid)
   // Popping needs a waiting job.
   `RFR_ASSERT_SAME(a_pop_nonempty, clock, reset, job_pop, !q_empty)

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// Testbench for report_frame_receiver: deframer predictor, random byte and tick traffic.
module tb;

   localparam int MAX_WORDS     = 8;
   localparam int MAX_FRAME     = 128;
   localparam int STORE_DEPTH   = rfr_pkg::HEADER_BYTES + 2 * MAX_WORDS;
   localparam int SETTLE_CYCLES = 8;
   localparam int TIMEOUT_NS    = 2_000_000;

   typedef struct {
      logic       kind;
      logic [7:0] value;
   } rx_request_type;

   typedef struct packed {
      logic [7:0]  node_address;
      logic [7:0]  device_type;
      logic [7:0]  error_code;
      logic [7:0]  power_level;
      logic [2:0]  word_index;
      logic [15:0] data_word;
      logic        word_valid;
      logic        words_truncated;
      logic        last;
   } report_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic req_tuser = rfr_pkg::REQ_BYTE;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic [rfr_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [rfr_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Settings as the block should hold them.
   logic [7:0]  cfg_head  = rfr_pkg::FRAME_HEAD_RESET;
   logic [7:0]  cfg_addr  = rfr_pkg::OWN_ADDRESS_RESET;
   logic [7:0]  cfg_query = rfr_pkg::QUERY_COMMAND_RESET;
   logic [15:0] cfg_gap   = rfr_pkg::GAP_TICKS_RESET;

   // Deframer state of the predictor.
   logic [7:0]  frame_pos   = '0;
   logic [7:0]  frame_len   = '0;
   logic [7:0]  frame_cmd   = '0;
   logic [7:0]  frame_sum   = '0;
   logic [15:0] quiet_ticks = '0;
   logic [7:0]  payload_copy [STORE_DEPTH];

   rx_request_type  rx_requests [$];
   report_word_type report_words_due [$];
   rx_request_type  next_req;
   logic            req_taken = 1'b0;
   int unsigned     requests_built = 0;
   int unsigned     failures = 0;
   int unsigned     sender_idle_pct = 0;
   int unsigned     receiver_stall_pct = 0;

   report_frame_receiver #(
      .MAX_WORDS(MAX_WORDS),
      .MAX_FRAME(MAX_FRAME)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   task automatic queue_report();
      int unsigned words, shown;
      report_word_type w;
      if (frame_len < rfr_pkg::HEADER_BYTES) return;
      words = (int'(frame_len) - rfr_pkg::HEADER_BYTES) / 2;
      shown = (words > MAX_WORDS) ? MAX_WORDS : words;
      w.node_address    = payload_copy[0];
      w.device_type     = payload_copy[1];
      w.error_code      = payload_copy[2];
      w.power_level     = payload_copy[3];
      w.words_truncated = (words > MAX_WORDS);
      if (shown == 0) begin
         w.word_index = '0;
         w.data_word  = '0;
         w.word_valid = 1'b0;
         w.last       = 1'b1;
         report_words_due.push_back(w);
      end else begin
         for (int k = 0; k < shown; k++) begin
            w.word_index = 3'(k);
            w.data_word  = {payload_copy[rfr_pkg::HEADER_BYTES + 2 * k + 1],
                            payload_copy[rfr_pkg::HEADER_BYTES + 2 * k]};
            w.word_valid = 1'b1;
            w.last       = (k + 1 == shown);
            report_words_due.push_back(w);
         end
      end
   endtask

   task automatic deframer_step(input logic kind, input logic [7:0] b);
      int idx;
      if (kind == rfr_pkg::REQ_TICK) begin
         if (quiet_ticks != 16'hFFFF) quiet_ticks = quiet_ticks + 16'd1;
      end else begin
         // A byte after a long silence is taken as a fresh head candidate.
         if (quiet_ticks > cfg_gap) frame_pos = '0;
         quiet_ticks = '0;
         frame_pos = frame_pos + 8'd1;
         if (frame_pos == rfr_pkg::POS_HEAD) begin
            if (b != cfg_head) frame_pos = '0;
         end else if (frame_pos == rfr_pkg::POS_ADDRESS) begin
            if (b != cfg_addr) frame_pos = '0;
         end else if (frame_pos == rfr_pkg::POS_COMMAND) begin
            frame_cmd = b;
         end else if (frame_pos == rfr_pkg::POS_LENGTH) begin
            frame_len = b;
            frame_sum = '0;
            if (rfr_pkg::FRAME_OVERHEAD + int'(b) > MAX_FRAME) frame_pos = '0;
         end else if (int'(frame_pos) < rfr_pkg::FRAME_OVERHEAD + int'(frame_len)) begin
            idx = int'(frame_pos) - rfr_pkg::FRAME_OVERHEAD;
            frame_sum = frame_sum + b;
            if (idx < STORE_DEPTH) payload_copy[idx] = b;
         end else begin
            if (b == frame_sum && frame_cmd == cfg_query) queue_report();
            frame_pos = '0;
         end
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   task automatic check_report_word();
      report_word_type want;
      if (report_words_due.size() == 0) begin
         $error("report word with none outstanding: tdata 0x%0h", rsp_tdata);
         failures++;
      end else begin
         want = report_words_due.pop_front();
         check_field("node_address", want.node_address, rsp_tdata[7:0]);
         check_field("device_type", want.device_type, rsp_tdata[15:8]);
         check_field("error_code", want.error_code, rsp_tdata[23:16]);
         check_field("power_level", want.power_level, rsp_tdata[31:24]);
         check_field("word_index", want.word_index, rsp_tdata[34:32]);
         check_field("data_word", want.data_word, rsp_tdata[50:35]);
         check_field("word_valid", want.word_valid, rsp_tuser[0]);
         check_field("words_truncated", want.words_truncated, rsp_tuser[1]);
         check_field("last", want.last, rsp_tlast);
      end
   endtask

   // Predict on every accepted request, then check any result taken at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) deframer_step(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) check_report_word();
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (rx_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            next_req = rx_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= next_req.kind;
            req_tdata <= next_req.value;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   task automatic push_req(input logic kind, input logic [7:0] value);
      rx_request_type r;
      r.kind = kind;
      r.value = value;
      rx_requests.push_back(r);
      requests_built++;
   endtask

   task automatic push_byte(input logic [7:0] value);
      push_req(rfr_pkg::REQ_BYTE, value);
   endtask

   task automatic push_ticks(input int unsigned n);
      repeat (n) push_req(rfr_pkg::REQ_TICK, 8'($urandom));
   endtask

   // Silence that never exceeds the gap, so the frame survives it.
   task automatic push_quiet(input int unsigned pct);
      int unsigned cap;
      cap = (cfg_gap < 3) ? cfg_gap : 3;
      if ($urandom_range(99) < pct) push_ticks($urandom_range(1, cap));
   endtask

   task automatic push_restart();
      if (cfg_gap <= 64) push_ticks(cfg_gap + $urandom_range(1, 3));
   endtask

   // A negative fill gives random payload bytes.
   task automatic push_frame(input logic [7:0] cmd, input int unsigned len, input bit sum_ok,
                             input int fill, input int unsigned tick_pct);
      logic [7:0] sum, b;
      sum = '0;
      push_byte(cfg_head);
      push_quiet(tick_pct);
      push_byte(cfg_addr);
      push_quiet(tick_pct);
      push_byte(cmd);
      push_quiet(tick_pct);
      push_byte(len[7:0]);
      if (rfr_pkg::FRAME_OVERHEAD + len <= MAX_FRAME) begin
         for (int i = 0; i < len; i++) begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            sum = sum + b;
            push_quiet(tick_pct);
            push_byte(b);
         end
         push_quiet(tick_pct);
         push_byte(sum_ok ? sum : sum ^ (8'd1 << $urandom_range(7)));
      end
   endtask

   task automatic push_random_traffic(input int unsigned quota);
      int unsigned goal, pick, r, len, n;
      logic [7:0] cmd;
      goal = requests_built + quota;
      while (requests_built < goal) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            r = $urandom_range(99);
            if (r < 60) len = $urandom_range(24);
            else if (r < 88) len = $urandom_range(25, 60);
            else if (r < 95) len = $urandom_range(61, MAX_FRAME - rfr_pkg::FRAME_OVERHEAD);
            else len = $urandom_range(MAX_FRAME - rfr_pkg::FRAME_OVERHEAD + 1, 255);
            cmd = ($urandom_range(99) < 75) ? cfg_query : 8'($urandom);
            push_frame(cmd, len, $urandom_range(99) < 88, -1, 8);
         end else if (pick < 80) begin
            // Cut header, sometimes with a foreign address.
            n = $urandom_range(1, 3);
            push_byte(cfg_head);
            if (n > 1)
               push_byte($urandom_range(1) ? cfg_addr : cfg_addr ^ 8'($urandom_range(1, 255)));
            if (n > 2) push_byte(8'($urandom));
            push_restart();
         end else if (pick < 90) begin
            n = $urandom_range(1, 6);
            repeat (n) push_byte(8'($urandom));
            push_restart();
         end else begin
            push_ticks($urandom_range(1, 3));
         end
      end
   endtask

   task automatic write_csr(input logic [rfr_pkg::CSR_INDEX_W-1:0] index,
                            input logic [rfr_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         rfr_pkg::REG_FRAME_HEAD:    cfg_head = value[7:0];
         rfr_pkg::REG_OWN_ADDRESS:   cfg_addr = value[7:0];
         rfr_pkg::REG_QUERY_COMMAND: cfg_query = value[7:0];
         rfr_pkg::REG_GAP_TICKS:     cfg_gap = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(input logic [7:0] head, input logic [7:0] addr,
                             input logic [7:0] query, input logic [15:0] gap);
      write_csr(rfr_pkg::REG_FRAME_HEAD, 16'(head));
      write_csr(rfr_pkg::REG_OWN_ADDRESS, 16'(addr));
      write_csr(rfr_pkg::REG_QUERY_COMMAND, 16'(query));
      write_csr(rfr_pkg::REG_GAP_TICKS, gap);
   endtask

   // The report engine lags the checksum byte, hence the settle time.
   task automatic wait_idle();
      while (rx_requests.size() != 0 || req_tvalid || report_words_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      #(TIMEOUT_NS);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      sender_idle_pct = 10;
      receiver_stall_pct = 63;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part on the reset settings.
      push_frame(cfg_query, 4, 1'b1, 8'h00, 0);
      push_frame(cfg_query, 5, 1'b1, 8'hFF, 0);
      push_frame(cfg_query, 3, 1'b1, -1, 0);
      push_frame(cfg_query, 0, 1'b1, -1, 0);
      push_frame(cfg_query, 6, 1'b1, -1, 0);
      push_frame(cfg_query, 21, 1'b1, -1, 0);
      push_frame(cfg_query, 22, 1'b1, -1, 0);
      push_frame(cfg_query, MAX_FRAME - rfr_pkg::FRAME_OVERHEAD + 1, 1'b1, -1, 0);
      push_frame(cfg_query, 255, 1'b1, -1, 0);
      push_frame(cfg_query, 8, 1'b0, -1, 0);
      push_frame(cfg_query ^ 8'h01, 8, 1'b1, -1, 0);
      push_byte(~cfg_head);
      push_byte(cfg_head);
      push_byte(~cfg_addr);
      push_frame(cfg_query, 4, 1'b1, -1, 0);
      wait_idle();

      set_config(8'h00, 8'hFF, 8'hFF, 16'd1);
      // Silence equal to the gap keeps the frame; one tick more drops it.
      push_byte(cfg_head);
      push_byte(cfg_addr);
      push_ticks(cfg_gap);
      push_byte(cfg_query);
      push_byte(8'd4);
      repeat (4) push_byte(8'h11);
      push_byte(8'h44);
      push_byte(cfg_head);
      push_byte(cfg_addr);
      push_ticks(cfg_gap + 1);
      push_frame(cfg_query, 6, 1'b1, -1, 0);
      push_frame(cfg_query, 8, 1'b1, -1, 100);
      wait_idle();

      sender_idle_pct = 63;
      receiver_stall_pct = 10;
      set_config(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(1, 3)));
      push_random_traffic(30);
      wait_idle();

      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      set_config(8'($urandom), 8'($urandom), 8'($urandom), 16'hFFFF);
      push_random_traffic(20);
      wait_idle();

      if (failures == 0 && report_words_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

[report_frame_receiver.f]
+incdir+hdl
hdl/rfr_pkg.sv
hdl/rfr_front.sv
hdl/rfr_job_fifo.sv
hdl/rfr_back.sv
hdl/report_frame_receiver.sv
sim/tb.sv
